/* sv/bpa_pkg.sv */
// Shared types and constants for the buddy page allocator.
`default_nettype none
package bpa_pkg;
    localparam int DEF_PAGE_COUNT = 1024;
    localparam int DEF_MAX_ORDER  = 4;
    localparam int PAGE_W  = 10;
    localparam int ORDER_W = 3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // datapath command
    typedef enum logic [3:0] {
        CMD_NONE      = 4'd0,
        CMD_LOAD      = 4'd1,
        CMD_SCAN      = 4'd2,
        CMD_RD_SELF   = 4'd3,
        CMD_RD_NEXT   = 4'd4,
        CMD_UNLINK    = 4'd5,
        CMD_SPLIT     = 4'd6,
        CMD_RD_PUSH   = 4'd7,
        CMD_PUSH      = 4'd8,
        CMD_RD_BUDDY  = 4'd9,
        CMD_MERGE     = 4'd10,
        CMD_DONE_OK   = 4'd11,
        CMD_DONE_FAIL = 4'd12,
        CMD_LINK      = 4'd13
    } cmd_t;

    typedef struct packed {
        logic op;
        logic order_bad;
        logic free_bad;
        logic list_found;
        logic scan_end;
        logic self_free;
        logic split_more;
        logic split_fits;
        logic buddy_ok;
        logic merge_more;
        logic unlink_for_push;
        logic clear_done;
    } stat_t;
endpackage
`default_nettype wire

/* sv/bpa_datapath.sv */
// Datapath: free-list memories, list heads, counters and working registers.
`default_nettype none
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int PAGE_COUNT = DEF_PAGE_COUNT,
    parameter int MAX_ORDER  = DEF_MAX_ORDER
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  cmd_t                    cmd,
    input  wire logic               in_op,
    input  wire logic [ORDER_W-1:0] in_order,
    input  wire logic [PAGE_W-1:0]  in_page,
    output stat_t                   stat,
    output logic                    res_ok,
    output logic [PAGE_W-1:0]       res_page,
    output logic [ORDER_W-1:0]      res_order
);
    localparam int AW = $clog2(PAGE_COUNT);
    localparam int LW = AW + 1;               // link width, MSB set means null
    localparam int NL = MAX_ORDER + 1;
    localparam int OW = $clog2(NL + 1);
    localparam logic [LW-1:0] NIL = LW'(1) << AW;

    // memories
    logic [LW-1:0]      next_mem [PAGE_COUNT];
    logic [LW-1:0]      prev_mem [PAGE_COUNT];
    logic [ORDER_W-1:0] ord_mem  [PAGE_COUNT];
    logic               head_mem [PAGE_COUNT];
    logic [LW-1:0]      list_head_reg [NL];

    logic               op_reg;
    logic [OW-1:0]      req_reg, cur_reg;
    logic [LW-1:0]      p_reg;             // working block
    logic [LW-1:0]      tgt_reg;           // block being unlinked / pushed
    logic [OW-1:0]      tgt_ord_reg;
    logic [LW-1:0]      rd_next_reg, rd_prev_reg;
    logic [ORDER_W-1:0] rd_ord_reg;
    logic               rd_head_reg;
    logic               ok_reg;
    logic [PAGE_W-1:0]  res_page_reg;
    logic [ORDER_W-1:0] res_order_reg;
    logic [AW-1:0]      clr_idx_reg;       // head flag clearing pass after reset
    logic               clr_busy_reg;

    logic [LW-1:0]      half;
    logic [LW-1:0]      buddy;
    logic [LW+1:0]      end_pg;
    logic [AW-1:0]      t_idx;
    logic [OW-1:0]      unl_ord;

    assign half  = LW'(1) << (cur_reg - OW'(1));
    assign buddy = p_reg ^ (LW'(1) << cur_reg);
    assign end_pg = (LW+2)'(in_page) + ((LW+2)'(1) << in_order);
    assign t_idx = tgt_reg[AW-1:0];
    assign unl_ord = (OW'(rd_ord_reg) > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : OW'(rd_ord_reg);

    always_comb
    begin
        stat.op          = op_reg;
        stat.order_bad   = OW'(in_order) > OW'(MAX_ORDER);
        stat.free_bad    = (end_pg > (LW+2)'(PAGE_COUNT))
                        || ((in_page & PAGE_W'((1 << in_order) - 1)) != '0);
        stat.list_found  = !list_head_reg[cur_reg[OW-1:0] < OW'(NL) ? cur_reg : '0][LW-1]
                        && cur_reg <= OW'(MAX_ORDER);
        stat.scan_end    = cur_reg >= OW'(MAX_ORDER);
        stat.self_free   = rd_head_reg;
        stat.split_more  = cur_reg > req_reg;
        stat.split_fits  = tgt_reg < LW'(PAGE_COUNT);
        stat.buddy_ok    = rd_head_reg && (OW'(rd_ord_reg) == cur_reg);
        stat.merge_more  = cur_reg < OW'(MAX_ORDER) && buddy < LW'(PAGE_COUNT);
        stat.unlink_for_push = rd_head_reg;
        stat.clear_done  = !clr_busy_reg;
    end

    logic [AW-1:0] rd_addr;
    always_comb
    begin
        case (cmd)
            CMD_RD_SELF:  rd_addr = p_reg[AW-1:0];
            CMD_RD_BUDDY: rd_addr = buddy[AW-1:0];
            default:      rd_addr = t_idx;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NL; i++) list_head_reg[i] <= NIL;
            ok_reg       <= 1'b0;
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(PAGE_COUNT - 1)) clr_busy_reg <= 1'b0;
            end
            case (cmd)
                CMD_UNLINK:
                begin
                    if (rd_prev_reg[LW-1]) list_head_reg[unl_ord] <= rd_next_reg;
                end
                CMD_PUSH:      list_head_reg[tgt_ord_reg] <= tgt_reg;
                CMD_DONE_OK:   ok_reg <= 1'b1;
                CMD_DONE_FAIL: ok_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_next_reg <= next_mem[rd_addr];
        rd_prev_reg <= prev_mem[rd_addr];
        rd_ord_reg  <= ord_mem[rd_addr];
        rd_head_reg <= head_mem[rd_addr];
        if (clr_busy_reg) head_mem[clr_idx_reg] <= 1'b0;
        else if (cmd == CMD_UNLINK) head_mem[t_idx] <= 1'b0;
        else if (cmd == CMD_PUSH) head_mem[t_idx] <= 1'b1;
        case (cmd)
            CMD_LOAD:
            begin
                op_reg  <= in_op;
                req_reg <= OW'(in_order);
                cur_reg <= OW'(in_order);
                p_reg   <= LW'(in_page);
                tgt_reg <= LW'(in_page);
            end
            CMD_SCAN: cur_reg <= cur_reg + OW'(1);
            CMD_RD_SELF:
            begin
                // alloc: target is list head
                if (!op_reg)
                begin
                    p_reg   <= list_head_reg[cur_reg];
                    tgt_reg <= list_head_reg[cur_reg];
                end
            end
            CMD_RD_NEXT: ;
            CMD_UNLINK:
            begin
                if (!rd_prev_reg[LW-1]) next_mem[rd_prev_reg[AW-1:0]] <= rd_next_reg;
                if (!rd_next_reg[LW-1]) prev_mem[rd_next_reg[AW-1:0]] <= rd_prev_reg;
            end
            CMD_SPLIT:
            begin
                cur_reg     <= cur_reg - OW'(1);
                tgt_reg     <= p_reg + half;
                tgt_ord_reg <= cur_reg - OW'(1);
            end
            CMD_RD_PUSH:
            begin
                // free: the merged block is pushed at the reached order
                tgt_reg     <= p_reg;
                tgt_ord_reg <= cur_reg;
            end
            CMD_LINK:
            begin
                ord_mem[t_idx]  <= ORDER_W'(tgt_ord_reg);
                next_mem[t_idx] <= list_head_reg[tgt_ord_reg];
                if (!list_head_reg[tgt_ord_reg][LW-1])
                    prev_mem[list_head_reg[tgt_ord_reg][AW-1:0]] <= tgt_reg;
            end
            CMD_PUSH: prev_mem[t_idx] <= NIL;
            CMD_RD_BUDDY: tgt_reg <= buddy;
            CMD_MERGE:
            begin
                p_reg   <= p_reg & tgt_reg;
                cur_reg <= cur_reg + OW'(1);
            end
            CMD_DONE_OK:
            begin
                res_page_reg  <= PAGE_W'(p_reg);
                res_order_reg <= op_reg ? ORDER_W'(cur_reg) : ORDER_W'(req_reg);
            end
            CMD_DONE_FAIL:
            begin
                res_page_reg  <= '0;
                res_order_reg <= '0;
            end
            default: ;
        endcase
    end

    assign res_ok    = ok_reg;
    assign res_page  = ok_reg ? res_page_reg : '0;
    assign res_order = ok_reg ? res_order_reg : '0;
endmodule
`default_nettype wire

/* sv/bpa_ctrl.sv */
// Controller state machine sequencing alloc and free requests.
`default_nettype none
module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_op,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  stat_t     stat,
    output cmd_t      cmd
);
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_CHECK  = 14'b00000000000010,
        S_SCAN   = 14'b00000000000100,
        S_RDSELF = 14'b00000000001000,
        S_WAIT   = 14'b00000000010000,
        S_UNLINK = 14'b00000000100000,
        S_SPLIT  = 14'b00000001000000,
        S_RDPUSH = 14'b00000010000000,
        S_WPUSH  = 14'b00000100000000,
        S_PUSH   = 14'b00001000000000,
        S_RDBUD  = 14'b00010000000000,
        S_WBUD   = 14'b00100000000000,
        S_FAIL   = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   bad_reg, bad_next;      // order or free check fail latched
    logic   upush_reg, upush_next;  // unlink precedes a push
    logic   mrg_reg, mrg_next;      // unlink is a merge step

    assign in_ready = (state_reg == S_IDLE) && stat.clear_done;

    always_comb
    begin
        state_next = state_reg;
        bad_next   = bad_reg;
        upush_next = upush_reg;
        mrg_next   = mrg_reg;
        cmd        = CMD_NONE;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            if (in_valid && stat.clear_done)
            begin
                cmd = CMD_LOAD;
                bad_next = 1'b0;
                if (stat.order_bad) bad_next = 1'b1;
                else if (in_op == OP_FREE && stat.free_bad) bad_next = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (bad_reg) state_next = S_FAIL;
                else if (stat.op == OP_ALLOC) state_next = S_SCAN;
                else
                begin
                    cmd = CMD_RD_SELF;
                    state_next = S_RDSELF;
                end
            end
            S_SCAN:
            begin
                if (stat.list_found)
                begin
                    cmd = CMD_RD_SELF;
                    state_next = S_RDSELF;
                end
                else if (stat.scan_end) state_next = S_FAIL;
                else cmd = CMD_SCAN;
            end
            S_RDSELF:
            begin
                // alloc: read issued now on the latched head
                cmd = CMD_RD_NEXT;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.op == OP_ALLOC)
                begin
                    upush_next = 1'b0;
                    mrg_next = 1'b0;
                    cmd = CMD_UNLINK;
                    state_next = S_UNLINK;
                end
                else if (stat.self_free) state_next = S_FAIL;
                else
                begin
                    if (stat.merge_more)
                    begin
                        cmd = CMD_RD_BUDDY;
                        state_next = S_RDBUD;
                    end
                    else
                    begin
                        cmd = CMD_RD_PUSH;
                        state_next = S_RDPUSH;
                    end
                end
            end
            S_UNLINK:
            begin
                if (upush_reg)
                begin
                    cmd = CMD_LINK;
                    state_next = S_PUSH;
                end
                else if (mrg_reg)
                begin
                    cmd = CMD_MERGE;
                    state_next = S_WPUSH;
                end
                else state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (stat.op == OP_FREE || !stat.split_more)
                begin
                    cmd = CMD_DONE_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd = CMD_SPLIT;
                    state_next = S_RDPUSH;
                end
            end
            S_RDPUSH:
            begin
                // upper half past the last page is dropped
                if (stat.op == OP_ALLOC && !stat.split_fits) state_next = S_SPLIT;
                else
                begin
                    cmd = CMD_RD_NEXT;
                    state_next = S_WPUSH;
                end
            end
            S_WPUSH:
            begin
                if (mrg_reg)
                begin
                    // after a merge, look for the next buddy
                    mrg_next = 1'b0;
                    if (stat.merge_more)
                    begin
                        cmd = CMD_RD_BUDDY;
                        state_next = S_RDBUD;
                    end
                    else
                    begin
                        cmd = CMD_RD_PUSH;
                        state_next = S_RDPUSH;
                    end
                end
                else if (stat.unlink_for_push)
                begin
                    upush_next = 1'b1;
                    cmd = CMD_UNLINK;
                    state_next = S_UNLINK;
                end
                else
                begin
                    cmd = CMD_LINK;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                upush_next = 1'b0;
                cmd = CMD_PUSH;
                state_next = S_SPLIT;
            end
            S_RDBUD:
            begin
                cmd = CMD_RD_NEXT;
                state_next = S_WBUD;
            end
            S_WBUD:
            begin
                if (stat.buddy_ok)
                begin
                    mrg_next = 1'b1;
                    cmd = CMD_UNLINK;
                    state_next = S_UNLINK;
                end
                else
                begin
                    cmd = CMD_RD_PUSH;
                    state_next = S_RDPUSH;
                end
            end
            S_FAIL:
            begin
                cmd = CMD_DONE_FAIL;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bad_reg   <= 1'b0;
            upush_reg <= 1'b0;
            mrg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bad_reg   <= bad_next;
            upush_reg <= upush_next;
            mrg_reg   <= mrg_next;
        end
    end

`ifndef SYNTHESIS
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_ready_out: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

/* sv/buddy_page_allocator_core.sv */
// Top level of the buddy page allocator.
// Usage:
//   s_axis carries one request: tdata = {opcode, block_order, page_index}
//   from bit 0 up. m_axis returns one result per request:
//   tdata = {ok, result_page, final_order} from bit 0 up.
//   A request is taken only when the block is idle; it is worked through a
//   controller FSM over list-link memories. An alloc scans up from the
//   requested order past empty lists, then splits the block found level by
//   level, pushing each upper half onto its free list (after unlinking it
//   when it first leaves another list). A free merges with each buddy that
//   is free at the same order and pushes the merged block. Bad order or
//   page, a double free and a failed alloc return a failure result.
//   The next request is taken the cycle after the result is accepted.
//   The result waits in m_axis until taken; s_tready stays low meanwhile.
//   Reset empties every free list; a clearing pass over every page then
//   zeroes the head flags with s_tready low. Software frees pages to populate
//   the lists. Link and order memories are not cleared.
`default_nettype none
module buddy_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int PAGE_COUNT = DEF_PAGE_COUNT,
    parameter int MAX_ORDER  = DEF_MAX_ORDER
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // opcode, block_order, page_index
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // ok, result_page, final_order
);
    cmd_t  cmd;
    stat_t stat;
    logic               res_ok;
    logic [PAGE_W-1:0]  res_page;
    logic [ORDER_W-1:0] res_order;

    bpa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_op(s_tdata[0]), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    bpa_datapath #(.PAGE_COUNT(PAGE_COUNT), .MAX_ORDER(MAX_ORDER)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_op(s_tdata[0]), .in_order(s_tdata[3:1]), .in_page(s_tdata[13:4]),
        .stat(stat), .res_ok(res_ok), .res_page(res_page), .res_order(res_order)
    );

    assign m_tdata = {2'b00, res_order, res_page, res_ok};
endmodule
`default_nettype wire
